FILE: rtl/core/cop_pkg.sv
// ----------------------------------------------------------------------------
// cop_pkg
// shared types, codes and helpers for the circle outline pixel generator
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned RadiusW  = 14;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 2;

  // item kind carried on the input tuser
  localparam logic KindStart = 1'b0;
  localparam logic KindStep  = 1'b1;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_STEP,
    MODE_IDLE
  } run_mode_e;

  // one run: everything the serializer needs to produce its pixels
  typedef struct packed {
    run_mode_e           mode;
    logic [CoordW-1:0]   cx;
    logic [CoordW-1:0]   cy;
    logic [ColorW-1:0]   col;
    logic [CoordW-1:0]   a;
    logic [CoordW-1:0]   b;
    logic                done;
  } run_t;

  // index of the final pixel of a run
  function automatic logic [IdxW-1:0] last_idx(run_mode_e mode);
    logic [IdxW-1:0] res;
    case (mode)
      MODE_START: res = IdxW'(3);
      MODE_STEP:  res = IdxW'(7);
      default:    res = '0;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/cop_state.sv
// ----------------------------------------------------------------------------
// cop_state
// midpoint decision state, updated once per accepted item
// ----------------------------------------------------------------------------
module cop_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          kind_i,
  input  logic [cop_pkg::CoordW-1:0]    center_x_i,
  input  logic [cop_pkg::CoordW-1:0]    center_y_i,
  input  logic [cop_pkg::RadiusW-1:0]   radius_i,
  input  logic [cop_pkg::ColorW-1:0]    color_i,
  output cop_pkg::run_t                 run_o
);
  import cop_pkg::*;

  logic [CoordW-1:0] step_x_q, step_x_d;
  logic [CoordW-1:0] step_y_q, step_y_d;
  logic [CoordW-1:0] dterm_q, dterm_d;
  logic [CoordW-1:0] x_inc_q, x_inc_d;
  logic [CoordW-1:0] y_inc_q, y_inc_d;
  logic [CoordW-1:0] cx_q, cx_d;
  logic [CoordW-1:0] cy_q, cy_d;
  logic [ColorW-1:0] col_q, col_d;
  logic              active_q, active_d;

  logic [CoordW-1:0] r_ext;
  logic              move_y;
  logic [CoordW-1:0] y_inc_stp;
  logic [CoordW-1:0] x_inc_stp;
  logic [CoordW-1:0] y_add;
  logic              done;

  always_comb begin
    r_ext     = CoordW'(radius_i);
    move_y    = ~dterm_q[CoordW-1];
    y_inc_stp = move_y ? y_inc_q + CoordW'(2) : y_inc_q;
    x_inc_stp = x_inc_q + CoordW'(2);
    y_add     = move_y ? y_inc_stp : '0;

    step_x_d = step_x_q;
    step_y_d = step_y_q;
    dterm_d  = dterm_q;
    x_inc_d  = x_inc_q;
    y_inc_d  = y_inc_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    col_d    = col_q;
    active_d = active_q;
    done     = 1'b1;

    run_o      = '0;
    run_o.mode = MODE_IDLE;

    if (kind_i == KindStart) begin
      step_x_d = '0;
      step_y_d = r_ext;
      dterm_d  = CoordW'(1) - r_ext;
      x_inc_d  = CoordW'(1);
      y_inc_d  = '0 - (r_ext << 1);
      cx_d     = center_x_i;
      cy_d     = center_y_i;
      col_d    = color_i;
      done     = (radius_i == '0);
      active_d = ~done;
      run_o.mode = MODE_START;
      run_o.cx   = center_x_i;
      run_o.cy   = center_y_i;
      run_o.col  = color_i;
      run_o.a    = '0;
      run_o.b    = r_ext;
      run_o.done = done;
    end else if (active_q) begin
      step_x_d = step_x_q + CoordW'(1);
      step_y_d = move_y ? step_y_q - CoordW'(1) : step_y_q;
      y_inc_d  = y_inc_stp;
      x_inc_d  = x_inc_stp;
      dterm_d  = dterm_q + y_add + x_inc_stp;
      // finished once the column offset reaches the row offset
      done     = ~($signed(step_x_d) < $signed(step_y_d));
      active_d = ~done;
      run_o.mode = MODE_STEP;
      run_o.cx   = cx_q;
      run_o.cy   = cy_q;
      run_o.col  = col_q;
      run_o.a    = step_x_d;
      run_o.b    = step_y_d;
      run_o.done = done;
    end else begin
      run_o.done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q <= '0;
      step_y_q <= '0;
      dterm_q  <= '0;
      x_inc_q  <= CoordW'(1);
      y_inc_q  <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      col_q    <= '0;
      active_q <= 1'b0;
    end else if (accept_i) begin
      step_x_q <= step_x_d;
      step_y_q <= step_y_d;
      dterm_q  <= dterm_d;
      x_inc_q  <= x_inc_d;
      y_inc_q  <= y_inc_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      col_q    <= col_d;
      active_q <= active_d;
    end
  end

endmodule

FILE: rtl/core/cop_emit.sv
// ----------------------------------------------------------------------------
// cop_emit
// run register and pixel serializer feeding the output register
// ----------------------------------------------------------------------------
module cop_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  cop_pkg::run_t                   run_i,
  output logic                            load_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cop_pkg::OutDataW-1:0]    out_data_o,
  output logic [cop_pkg::OutUserW-1:0]    out_user_o,
  output logic                            out_last_o
);
  import cop_pkg::*;

  cop_pkg::run_t     run_q;
  logic              run_valid_q;
  logic [IdxW-1:0]   idx_q;

  logic              out_valid_q;
  logic [CoordW-1:0] px_q, px_d;
  logic [CoordW-1:0] py_q, py_d;
  logic [ColorW-1:0] pc_q, pc_d;
  logic              pv_q, pv_d;
  logic              pl_q, pl_d;
  logic              pd_q, pd_d;

  logic              out_free;
  logic              fire;
  logic              run_end;
  logic              swap, xneg, yneg;
  logic [CoordW-1:0] xmag, ymag;

  assign out_free     = ~out_valid_q | out_ready_i;
  assign fire         = run_valid_q & out_free;
  assign run_end      = fire & (idx_q == last_idx(run_q.mode));
  assign load_ready_o = ~run_valid_q | run_end;

  // octant mirroring from the pixel index
  always_comb begin
    if (run_q.mode == MODE_START) begin
      swap = idx_q[1];
      xneg = idx_q[0];
      yneg = idx_q[0];
    end else begin
      swap = idx_q[2];
      xneg = idx_q[0];
      yneg = idx_q[1];
    end
    xmag = swap ? run_q.b : run_q.a;
    ymag = swap ? run_q.a : run_q.b;

    if (run_q.mode == MODE_IDLE) begin
      px_d = '0;
      py_d = '0;
      pc_d = '0;
      pv_d = 1'b0;
    end else begin
      px_d = xneg ? run_q.cx - xmag : run_q.cx + xmag;
      py_d = yneg ? run_q.cy - ymag : run_q.cy + ymag;
      pc_d = run_q.col;
      pv_d = 1'b1;
    end
    pl_d = (idx_q == last_idx(run_q.mode));
    pd_d = pl_d & run_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load_i) begin
      run_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (run_end) begin
      run_valid_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      px_q <= px_d;
      py_q <= py_d;
      pc_q <= pc_d;
      pv_q <= pv_d;
      pl_q <= pl_d;
      pd_q <= pd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {pc_q, py_q, px_q};
  assign out_user_o  = {pd_q, pv_q};
  assign out_last_o  = pl_q;

endmodule

FILE: rtl/core/circle_outline_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// circle_outline_pixel_generator_core
// midpoint circle outline rasterizer with stream ports
// ----------------------------------------------------------------------------
// A start transaction (tuser 0) latches center, radius and color and yields
// the four axis pixels; a step transaction (tuser 1) advances the decision
// state and yields the eight mirrored pixels; a step with no circle in
// progress yields one invalid result. The pixel serializer puts out one
// result per cycle while the output register is free. The decision
// state is updated as a transaction is taken, and the next transaction is taken
// in the cycle the serializer issues the last pixel of the current run, so runs
// follow each other with no gap while the output register is not stalled.
// Duplicate pixels where the column offset equals the row offset are kept.
// tlast marks the final result of a run, and tuser bit 1 on that result says
// the circle is finished. All coordinates wrap in 16 bits.
// ----------------------------------------------------------------------------
module circle_outline_pixel_generator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] center_x, [31:16] center_y, [45:32] radius, [61:46] color
  input  logic [cop_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] kind
  input  logic                            s_axis_tuser,
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color
  output logic [cop_pkg::OutDataW-1:0]    m_axis_tdata,
  // [0] pixel_valid, [1] done_res
  output logic [cop_pkg::OutUserW-1:0]    m_axis_tuser,
  output logic                            m_axis_tlast
);
  import cop_pkg::*;

  logic   accept;
  logic   load_ready;
  run_t   run;

  // take a transaction whenever the run register is empty or draining
  assign s_axis_tready = load_ready;
  assign accept        = s_axis_tvalid & load_ready;

  // decision state and run descriptor
  cop_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (s_axis_tuser),
    .center_x_i (s_axis_tdata[15:0]),
    .center_y_i (s_axis_tdata[31:16]),
    .radius_i   (s_axis_tdata[45:32]),
    .color_i    (s_axis_tdata[61:46]),
    .run_o      (run)
  );

  // per-pixel serializer with output register
  cop_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .run_i        (run),
    .load_ready_o (load_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

FILE: rtl/core/cop_checker.sv
// ----------------------------------------------------------------------------
// cop_checker
// port-level checks for the circle outline pixel generator
// ----------------------------------------------------------------------------
module cop_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [cop_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic [cop_pkg::OutUserW-1:0]    m_axis_tuser,
  input  logic                            m_axis_tlast
);
  import cop_pkg::*;

  // finished flag only on the final result of a run
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("done flag on a result that is not last");

  // an invalid result is the lone, finished result of an idle step
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1]
      && (m_axis_tdata == '0))
    else $error("invalid result malformed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // with the output stalled and full, no new transaction can be taken
  // after one more is already waiting in the run register
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && $past(m_axis_tvalid && !m_axis_tready)
      && $past(s_axis_tvalid && s_axis_tready) |-> !s_axis_tready)
    else $error("transaction taken while output is blocked");

endmodule

bind circle_outline_pixel_generator_core cop_checker u_cop_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the circle outline pixel generator core
// ----------------------------------------------------------------------------
// Drives start and step transactions into the slave stream and compares every
// pixel transaction on the master stream, field by field, against a
// midpoint-circle predictor kept in a small scoreboard class. A directed
// opening covers the special cases. A random part follows, made mostly of
// whole circles. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import cop_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned ItemGoal  = 500;

  // one expected pixel transaction on the master side
  typedef struct {
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [ColorW-1:0] col;
    logic              pix_valid;
    logic              last;
    logic              done;
  } pixel_t;

  // midpoint circle predictor plus the queue of pixels still owed by the core
  class circle_scoreboard;
    pixel_t            pixels_due[$];
    logic [CoordW-1:0] col_off, row_off, decision, x_inc, y_inc;
    logic [CoordW-1:0] cen_x, cen_y;
    logic [ColorW-1:0] color;
    bit                drawing;
    int unsigned       errors;

    function new();
      col_off  = '0;
      row_off  = '0;
      decision = '0;
      x_inc    = 16'd1;
      y_inc    = '0;
      cen_x    = '0;
      cen_y    = '0;
      color    = '0;
      drawing  = 1'b0;
      errors   = 0;
    endfunction

    function pixel_t lit(logic [CoordW-1:0] px, logic [CoordW-1:0] py);
      pixel_t p;
      p.px        = px;
      p.py        = py;
      p.col       = color;
      p.pix_valid = 1'b1;
      p.last      = 1'b0;
      p.done      = 1'b0;
      return p;
    endfunction

    // work out the pixels of one accepted input transaction
    function void note_input(logic kind, logic [InDataW-1:0] data);
      pixel_t            run [8];
      int unsigned       n;
      logic [CoordW-1:0] rad;
      logic [CoordW-1:0] a, b;
      if (kind == KindStart) begin
        rad      = {2'b00, data[45:32]};
        cen_x    = data[15:0];
        cen_y    = data[31:16];
        color    = data[61:46];
        col_off  = '0;
        row_off  = rad;
        decision = 16'd1 - rad;
        x_inc    = 16'd1;
        y_inc    = 16'd0 - (rad << 1);
        drawing  = 1'b1;
        run[0]   = lit(cen_x, cen_y + rad);
        run[1]   = lit(cen_x, cen_y - rad);
        run[2]   = lit(cen_x + rad, cen_y);
        run[3]   = lit(cen_x - rad, cen_y);
        n        = 4;
      end else if (!drawing) begin
        // step with nothing in progress: one empty pixel flagged done
        run[0]           = lit('0, '0);
        run[0].col       = '0;
        run[0].pix_valid = 1'b0;
        run[0].last      = 1'b1;
        run[0].done      = 1'b1;
        pixels_due.push_back(run[0]);
        return;
      end else begin
        // move inward first when the decision term is non-negative
        if ($signed(decision) >= 0) begin
          row_off  = row_off - 16'd1;
          y_inc    = y_inc + 16'd2;
          decision = decision + y_inc;
        end
        col_off  = col_off + 16'd1;
        x_inc    = x_inc + 16'd2;
        decision = decision + x_inc;
        a        = col_off;
        b        = row_off;
        run[0]   = lit(cen_x + a, cen_y + b);
        run[1]   = lit(cen_x - a, cen_y + b);
        run[2]   = lit(cen_x + a, cen_y - b);
        run[3]   = lit(cen_x - a, cen_y - b);
        run[4]   = lit(cen_x + b, cen_y + a);
        run[5]   = lit(cen_x - b, cen_y + a);
        run[6]   = lit(cen_x + b, cen_y - a);
        run[7]   = lit(cen_x - b, cen_y - a);
        n        = 8;
      end
      run[n-1].last = 1'b1;
      run[n-1].done = !($signed(col_off) < $signed(row_off));
      if (run[n-1].done) begin
        drawing = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
        pixels_due.push_back(run[i]);
      end
    endfunction

    function void report(string field, logic [CoordW-1:0] want, logic [CoordW-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    // compare one accepted pixel transaction with the oldest expectation
    function void check_result(logic [OutDataW-1:0] data, logic [OutUserW-1:0] user,
                               logic tlast);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, actual data %h user %b last %b",
                 $time, data, user, tlast);
        return;
      end
      want = pixels_due.pop_front();
      if (data[15:0] !== want.px)      report("pixel_x", want.px, data[15:0]);
      if (data[31:16] !== want.py)     report("pixel_y", want.py, data[31:16]);
      if (data[47:32] !== want.col)    report("pixel_color", want.col, data[47:32]);
      if (user[0] !== want.pix_valid) begin
        report("pixel_valid", CoordW'(want.pix_valid), CoordW'(user[0]));
      end
      if (user[1] !== want.done) begin
        report("done_res", CoordW'(want.done), CoordW'(user[1]));
      end
      if (tlast !== want.last) begin
        report("last", CoordW'(want.last), CoordW'(tlast));
      end
    endfunction

    function int unsigned pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tuser = KindStart;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [OutUserW-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  circle_scoreboard      sb;
  bit                    idling = 1'b1;
  int unsigned           rx_hold = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           items_sent = 0;

  circle_outline_pixel_generator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idling || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side stalls
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold       <= gap_len();
    end
  end

  // transaction monitor: feeds the predictor and checks pixels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles", $time, IdleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one input transaction, wait for it to be taken, then maybe idle
  task automatic send_item(input logic kind, input logic [15:0] cx, input logic [15:0] cy,
                           input logic [13:0] rad, input logic [15:0] col);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, col, rad, cy, cx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic step_circle();
    send_item(KindStep, 16'($urandom), 16'($urandom), 14'($urandom), 16'($urandom));
  endtask

  // a start followed by a number of steps, content random
  task automatic draw_circle(input logic [13:0] rad, input int unsigned steps);
    send_item(KindStart, 16'($urandom), 16'($urandom), rad, 16'($urandom));
    repeat (steps) step_circle();
  endtask

  initial begin
    int unsigned roll;
    int unsigned steps;
    bit          paused;
    logic [13:0] rad;
    sb     = new();
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: step before any circle, zero radius, step after finish
    step_circle();
    send_item(KindStart, 16'h0000, 16'h0000, 14'd0, 16'h0000);
    step_circle();
    // extreme center, radius and color, coordinates wrap
    send_item(KindStart, 16'h7FFF, 16'h8000, 14'h3FFF, 16'hFFFF);
    repeat (3) step_circle();
    // new start abandons the big circle; radius one ends after a single step
    send_item(KindStart, 16'h8000, 16'h7FFF, 14'd1, 16'hA5A5);
    step_circle();
    step_circle();
    // a small circle drawn to its end, duplicates at the diagonal included
    send_item(KindStart, 16'd100, 16'hFFCE, 14'd10, 16'h1234);
    repeat (9) step_circle();

    // random part
    while (items_sent < ItemGoal) begin
      idling = ($urandom_range(0, 3) != 0);
      if (!paused && items_sent >= ItemGoal / 2) begin
        // hold off the sender until every owed pixel has come out
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        // let the monitor note the last accepted transaction first
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        step_circle();
      end else if (roll < 20) begin
        draw_circle(14'($urandom), $urandom_range(0, 4));
      end else begin
        rad   = 14'($urandom_range(0, 40));
        steps = (rad * 3) / 4 + 2;
        if ($urandom_range(0, 99) < 15) begin
          steps = $urandom_range(0, steps);
        end
        draw_circle(rad, steps);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
